FILE: hdl/nsd_pkg.sv
// Shared types, constants and the sine table generator for the NCO sine/PWM block.
// Used by nsd_back, the top level and the testbench; depends on nothing else.
package nsd_pkg;

	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] CFG_MARK_STEP     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPACE_STEP    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_MARK    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_PWM_MODULUS   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_INTERP_ENABLE = 3'd4;

	localparam logic [31:0] DUTY_BIAS    = 32'd32767;
	localparam logic [16:0] DUTY_DIVISOR = 17'd65535;
	localparam logic [63:0] TWO_PI_Q28   = 64'd1686629713;

	typedef struct packed {
		logic [15:0] modulus;
		logic        interp;
	} back_cfg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_BLEND,
		BK_SCALE,
		BK_DONE
	} back_state_t;

	// Sine of 2*pi*j/2^tib in Q15 for the first quarter wave, from a Q28 Taylor series.
	function automatic logic [63:0] quarter_sine(input logic [63:0] j, input int tib);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] acc;
		logic [63:0]        r;
		x    = (TWO_PI_Q28 * j) >> tib;
		x2   = (x * x) >> 28;
		term = x;
		acc  = $signed(x);
		term = ((term * x2) >> 28) / 64'd6;
		acc  = acc - $signed(term);
		term = ((term * x2) >> 28) / 64'd20;
		acc  = acc + $signed(term);
		term = ((term * x2) >> 28) / 64'd42;
		acc  = acc - $signed(term);
		term = ((term * x2) >> 28) / 64'd72;
		acc  = acc + $signed(term);
		term = ((term * x2) >> 28) / 64'd110;
		acc  = acc - $signed(term);
		term = ((term * x2) >> 28) / 64'd156;
		acc  = acc + $signed(term);
		if (acc < 0) begin
			acc = 64'sd0;
		end
		r = (64'(acc) * 64'd32767 + (64'd1 << 27)) >> 28;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		return r;
	endfunction

	// Full-period table entry k, built from the quarter wave by symmetry.
	function automatic logic [15:0] sine_entry(input int k, input int tib);
		logic [63:0] qlen;
		logic [63:0] quad;
		logic [63:0] rem;
		logic [63:0] v;
		qlen = 64'd1 << (tib - 2);
		quad = 64'(k) >> (tib - 2);
		rem  = 64'(k) & (qlen - 64'd1);
		v    = quad[0] ? quarter_sine(qlen - rem, tib) : quarter_sine(rem, tib);
		return quad[1] ? 16'(-v) : v[15:0];
	endfunction

endpackage

FILE: hdl/nsd_front.sv
// Front end of the NCO: accepts tick items and advances the phase accumulator.
// Depends on no other file; pushes phases into the queue.
module nsd_front #(
	parameter int PHASE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic                  restart,
	input  logic [PHASE_BITS-1:0] step,
	input  logic                  q_full,
	output logic                  q_push,
	output logic [PHASE_BITS-1:0] q_data
);

	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] phase_d;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;
	assign phase_d  = (restart ? '0 : phase_q) + step;
	assign q_data   = phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (q_push) begin
			phase_q <= phase_d;
		end
	end

endmodule

FILE: hdl/nsd_fifo.sv
// Two-entry queue that carries phases from the front end to the back end.
// Self-contained; both sides stall independently on full and empty.
module nsd_fifo #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: hdl/nsd_back.sv
// Back end of the NCO: sine table lookup, interpolation, PWM duty scaling, output register.
// Depends on nsd_pkg for the table generator, configuration struct and state type.
module nsd_back #(
	parameter int TABLE_INDEX_BITS = 10,
	parameter int PHASE_BITS       = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	output logic                  q_pop,
	input  logic [PHASE_BITS-1:0] q_data,
	input  nsd_pkg::back_cfg_t    cfg,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata
);

	localparam int TblSize  = 1 << TABLE_INDEX_BITS;
	localparam int FracBits = PHASE_BITS - TABLE_INDEX_BITS;

	logic [15:0] rom [TblSize];

	for (genvar k = 0; k < TblSize; k++) begin : g_rom
		assign rom[k] = nsd_pkg::sine_entry(k, TABLE_INDEX_BITS);
	end

	nsd_pkg::back_state_t state_q;
	nsd_pkg::back_state_t state_d;

	logic out_free;
	logic rom_en;
	logic blend_en;
	logic scale_en;
	logic out_load;

	logic [PHASE_BITS-1:0]       phase_q;
	logic [TABLE_INDEX_BITS-1:0] idx;
	logic [TABLE_INDEX_BITS-1:0] idx_next;
	logic [15:0]                 a_q;
	logic [15:0]                 b_q;
	logic [15:0]                 sample_q;
	logic [31:0]                 prod_q;
	logic                        out_valid_q;
	logic [15:0]                 out_sample_q;
	logic [15:0]                 out_duty_q;

	logic signed [16:0]          diff;
	logic signed [FracBits+17:0] blend_prod;
	logic signed [FracBits+17:0] blend_shift;
	logic signed [16:0]          blend_sum;
	logic [15:0]                 level;
	logic [31:0]                 biased;
	logic [16:0]                 rem;
	logic [16:0]                 quot;
	logic [15:0]                 duty;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nsd_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_d = nsd_pkg::BK_READ;
				end
			end
			nsd_pkg::BK_READ: state_d = nsd_pkg::BK_BLEND;
			nsd_pkg::BK_BLEND: state_d = nsd_pkg::BK_SCALE;
			nsd_pkg::BK_SCALE: state_d = nsd_pkg::BK_DONE;
			nsd_pkg::BK_DONE: begin
				if (out_free) begin
					state_d = q_empty ? nsd_pkg::BK_IDLE : nsd_pkg::BK_READ;
				end
			end
			default: state_d = nsd_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		rom_en   = (state_q == nsd_pkg::BK_READ);
		blend_en = (state_q == nsd_pkg::BK_BLEND);
		scale_en = (state_q == nsd_pkg::BK_SCALE);
		out_load = (state_q == nsd_pkg::BK_DONE) && out_free;
		q_pop    = !q_empty && ((state_q == nsd_pkg::BK_IDLE) || out_load);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsd_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign idx      = phase_q[PHASE_BITS-1 -: TABLE_INDEX_BITS];
	assign idx_next = idx + TABLE_INDEX_BITS'(1);

	// The signed product shifted right floors, which matches the blend rule for both signs.
	assign diff        = $signed({b_q[15], b_q}) - $signed({a_q[15], a_q});
	assign blend_prod  = $signed({{(FracBits+1){diff[16]}}, diff})
	                   * $signed({18'd0, phase_q[FracBits-1:0]});
	assign blend_shift = blend_prod >>> FracBits;
	assign blend_sum   = $signed({a_q[15], a_q}) + blend_shift[16:0];

	// Adding 32768 to a Q15 sample flips its sign bit.
	assign level = {~sample_q[15], sample_q[14:0]};

	// Division by 65535: the high half plus one correction, since the remainder stays below twice it.
	assign biased = prod_q + nsd_pkg::DUTY_BIAS;
	assign rem    = {1'b0, biased[31:16]} + {1'b0, biased[15:0]};
	assign quot   = {1'b0, biased[31:16]} + 17'((rem >= nsd_pkg::DUTY_DIVISOR) ? 1 : 0);
	assign duty   = (quot > {1'b0, cfg.modulus}) ? cfg.modulus : quot[15:0];

	always_ff @(posedge clk) begin
		if (q_pop) begin
			phase_q <= q_data;
		end
		if (rom_en) begin
			a_q <= rom[idx];
			b_q <= rom[idx_next];
		end
		if (blend_en) begin
			sample_q <= cfg.interp ? blend_sum[15:0] : a_q;
		end
		if (scale_en) begin
			prod_q <= {16'd0, level} * {16'd0, cfg.modulus};
		end
		if (out_load) begin
			out_sample_q <= sample_q;
			out_duty_q   <= duty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_duty_q, out_sample_q};

endmodule

FILE: hdl/nco_sine_pwm_duty_top.sv
// Top level of the NCO sine/PWM duty block: configuration registers and the front/back split.
// Depends on nsd_pkg, nsd_front, nsd_fifo and nsd_back.
//
// Channel   Direction  Handshake              Payload
// s_        in         s_tvalid / s_tready    s_tdata[0] restart
// m_        out        m_tvalid / m_tready    m_tdata[15:0] sample_q15, [31:16] pwm_duty
// cfg_      in         cfg_valid / cfg_ready  cfg_index register, cfg_data value
//
// Each item passes through the back-end sequencer in order (table read, blend, scale, divide).
// The front end accepts a tick whenever the two-entry queue has room.
// Reset clears the phase, the queue and the output valid flag and loads register defaults.
// A stalled output holds its item while the front end keeps filling the queue.
module nco_sine_pwm_duty_top #(
	parameter int TABLE_INDEX_BITS = 10,
	parameter int PHASE_BITS       = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [0] restart
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [31:0]                     m_tdata,   // [15:0] sample_q15, [31:16] pwm_duty
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [nsd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data
);

	logic [31:0] mark_step_q;
	logic [31:0] space_step_q;
	logic        start_mark_q;
	logic [15:0] pwm_modulus_q;
	logic        interp_enable_q;

	logic [PHASE_BITS-1:0] step;
	nsd_pkg::back_cfg_t    back_cfg;

	logic                  q_push;
	logic [PHASE_BITS-1:0] q_wdata;
	logic                  q_full;
	logic                  q_pop;
	logic [PHASE_BITS-1:0] q_rdata;
	logic                  q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_step_q     <= 32'd0;
			space_step_q    <= 32'd0;
			start_mark_q    <= 1'b1;
			pwm_modulus_q   <= 16'hFFFF;
			interp_enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				nsd_pkg::CFG_MARK_STEP:     mark_step_q     <= cfg_data;
				nsd_pkg::CFG_SPACE_STEP:    space_step_q    <= cfg_data;
				nsd_pkg::CFG_START_MARK:    start_mark_q    <= cfg_data[0];
				nsd_pkg::CFG_PWM_MODULUS:   pwm_modulus_q   <= cfg_data[15:0];
				nsd_pkg::CFG_INTERP_ENABLE: interp_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign step            = start_mark_q ? mark_step_q[PHASE_BITS-1:0]
	                                      : space_step_q[PHASE_BITS-1:0];
	assign back_cfg.modulus = pwm_modulus_q;
	assign back_cfg.interp  = interp_enable_q;

	nsd_front #(
		.PHASE_BITS(PHASE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.restart (s_tdata[0]),
		.step    (step),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_wdata)
	);

	nsd_fifo #(
		.WIDTH(PHASE_BITS)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	nsd_back #(
		.TABLE_INDEX_BITS(TABLE_INDEX_BITS),
		.PHASE_BITS      (PHASE_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_data  (q_rdata),
		.cfg     (back_cfg),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

FILE: tb/nco_sine_pwm_duty_top_test.sv
// Self-checking testbench for nco_sine_pwm_duty_top: directed ticks, then random ticks under
// several register settings, checked against an in-bench oscillator model or fixed values.
// Depends on nsd_pkg and nco_sine_pwm_duty_top.
module nco_sine_pwm_duty_top_test;
	import nsd_pkg::*;

	localparam int                     CYCLE_LIMIT  = 500000;
	localparam int                     SETTLE       = 12;
	localparam int                     GAP_PERCENT  = 21;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam longint                 FRAC_MASK    = 64'h3F_FFFF;

	typedef struct {
		logic signed [15:0] sample;
		logic [15:0]        duty;
	} tone_out_t;

	typedef enum {ROW_CFG, ROW_TICK} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_INDEX_W-1:0] index;
		logic [31:0]            data;
		logic                   restart;
		bit                     typed;
		logic signed [15:0]     sample;
		logic [15:0]            duty;
	} plan_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;   // [0] restart
	logic                   m_tvalid;
	logic                   m_tready;
	logic [31:0]            m_tdata;   // [15:0] sample_q15, [31:16] pwm_duty
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [31:0]            cfg_data;

	logic signed [15:0] sine_table [0:1023];
	logic [31:0]        nco_phase;
	logic [31:0]        tone_mark;
	logic [31:0]        tone_space;
	logic               use_mark;
	logic [15:0]        duty_modulus;
	logic               blend_on;

	tone_out_t pending_results [$];
	plan_row_t plan [36];
	int        mismatches;
	int        cycles;
	bit        steady_flow;
	bit        in_flight;

	nco_sine_pwm_duty_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int quarter_amp(input int unsigned j);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          acc;
		longint unsigned r;
		x    = (64'd1686629713 * j) >> 10;
		x2   = (x * x) >> 28;
		term = x;
		acc  = longint'(x);
		for (int n = 1; n <= 6; n++) begin
			term = ((term * x2) >> 28) / $unsigned(64'((2 * n) * (2 * n + 1)));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		r = ($unsigned(acc) * 64'd32767 + (64'd1 << 27)) >> 28;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		return int'(r);
	endfunction

	function automatic tone_out_t tick_oscillator(input logic restart);
		logic [31:0]     step;
		int unsigned     idx;
		longint          frac;
		int              a;
		int              b;
		int              diff;
		int              smp;
		longint          adj;
		longint unsigned u;
		longint unsigned duty;
		tone_out_t       res;
		step = use_mark ? tone_mark : tone_space;
		if (restart) begin
			nco_phase = 32'd0;
		end
		nco_phase = nco_phase + step;
		idx = nco_phase[31:22];
		a   = sine_table[idx];
		smp = a;
		if (blend_on) begin
			b    = sine_table[(idx + 1) % 1024];
			diff = b - a;
			frac = nco_phase[21:0];
			if (diff >= 0) begin
				adj = (longint'(diff) * frac) >>> 22;
			end else begin
				adj = -((longint'(-diff) * frac + FRAC_MASK) >>> 22);
			end
			smp = a + int'(adj);
		end
		u    = $unsigned(64'(smp + 32768));
		duty = (u * duty_modulus + 64'd32767) / 64'd65535;
		if (duty > duty_modulus) begin
			duty = duty_modulus;
		end
		res.sample = smp[15:0];
		res.duty   = duty[15:0];
		return res;
	endfunction

	function automatic logic [31:0] random_tuning_word();
		case ($urandom_range(3))
			0: return $urandom_range(1, 1 << 24);
			1: return $urandom;
			2: return 32'hFFFF_FFFF - $urandom_range(0, 1 << 22);
			default: return 32'h0040_0000 * $urandom_range(0, 1023);
		endcase
	endfunction

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
		in_flight = 1'b0;
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
		if (in_flight) begin
			drain();
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_MARK_STEP:     tone_mark    = value;
			CFG_SPACE_STEP:    tone_space   = value;
			CFG_START_MARK:    use_mark     = value[0];
			CFG_PWM_MODULUS:   duty_modulus = value[15:0];
			CFG_INTERP_ENABLE: blend_on     = value[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_tick(input logic restart, input bit typed,
			input logic signed [15:0] sample, input logic [15:0] duty);
		tone_out_t want;
		while (!steady_flow && $urandom_range(99) < GAP_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, restart};
		do @(posedge clk); while (!s_tready);
		want = tick_oscillator(restart);
		if (typed) begin
			want.sample = sample;
			want.duty   = duty;
		end
		pending_results.push_back(want);
		in_flight = 1'b1;
	endtask

	always @(posedge clk) begin : result_check
		tone_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				if (mismatches < 10) begin
					$display("unexpected item: sample %0d duty %0d",
						$signed(m_tdata[15:0]), m_tdata[31:16]);
				end
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[15:0] !== want.sample || m_tdata[31:16] !== want.duty) begin
					if (mismatches < 10) begin
						$display("mismatch: sample exp %0d got %0d, duty exp %0d got %0d",
							want.sample, $signed(m_tdata[15:0]), want.duty, m_tdata[31:16]);
					end
					mismatches++;
				end
			end
		end
		m_tready <= steady_flow || ($urandom_range(99) >= GAP_PERCENT);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("nco_sine_pwm_duty_top_test: FAIL");
			$finish;
		end
	end

	initial begin
		logic [31:0] qlen;
		int          q;
		int          r;
		int          v;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = 8'd0;
		m_tready     = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_MARK_STEP;
		cfg_data     = 32'd0;
		mismatches   = 0;
		cycles       = 0;
		steady_flow  = 1'b0;
		in_flight    = 1'b0;
		nco_phase    = 32'd0;
		tone_mark    = 32'd0;
		tone_space   = 32'd0;
		use_mark     = 1'b1;
		duty_modulus = 16'd65535;
		blend_on     = 1'b0;
		qlen         = 32'd256;
		for (int k = 0; k < 1024; k++) begin
			q = k / 256;
			r = k % 256;
			v = (q % 2 == 1) ? quarter_amp(qlen - r) : quarter_amp(r);
			sine_table[k] = (q >= 2) ? 16'(-v) : 16'(v);
		end

		plan = '{
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b0, 1'b1, 16'sd0,      16'd32768},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b1, 1'b1, 16'sd0,      16'd32768},
			'{ROW_CFG,  CFG_MARK_STEP,     32'h4000_0000, 1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b1, 1'b1, 16'sd32767,  16'd65535},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b0, 1'b1, 16'sd0,      16'd32768},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b0, 1'b1, -16'sd32767, 16'd1},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b0, 1'b1, 16'sd0,      16'd32768},
			'{ROW_CFG,  CFG_PWM_MODULUS,   32'd0,         1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b1, 1'b1, 16'sd32767,  16'd0},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b0, 1'b1, 16'sd0,      16'd0},
			'{ROW_CFG,  CFG_PWM_MODULUS,   32'd1,         1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b0, 1'b1, -16'sd32767, 16'd0},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b0, 1'b1, 16'sd0,      16'd1},
			'{ROW_CFG,  CFG_PWM_MODULUS,   32'd65535,     1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_CFG,  CFG_INTERP_ENABLE, 32'd1,         1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_CFG,  CFG_MARK_STEP,     32'h0020_0000, 1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b1, 1'b0, 16'sd0,      16'd0},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_CFG,  CFG_MARK_STEP,     32'h1234_5679, 1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_CFG,  CFG_SPACE_STEP,    32'hFFFF_FFFF, 1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_CFG,  CFG_START_MARK,    32'd0,         1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b1, 1'b0, 16'sd0,      16'd0},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_CFG,  CFG_SPARE_LO,      32'hFFFF_FFFF, 1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_CFG,  CFG_SPARE_HI,      32'hFFFF_FFFF, 1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_CFG,  CFG_INTERP_ENABLE, 32'd0,         1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b1, 1'b0, 16'sd0,      16'd0},
			'{ROW_CFG,  CFG_MARK_STEP,     32'hFFFF_FFFF, 1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_CFG,  CFG_START_MARK,    32'd1,         1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b0, 1'b0, 16'sd0,      16'd0},
			'{ROW_TICK, CFG_MARK_STEP,     32'd0,         1'b1, 1'b0, 16'sd0,      16'd0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				cfg_write(plan[i].index, plan[i].data);
			end else begin
				send_tick(plan[i].restart, plan[i].typed, plan[i].sample, plan[i].duty);
			end
		end

		for (int ph = 0; ph < 10; ph++) begin
			cfg_write(CFG_MARK_STEP, random_tuning_word());
			cfg_write(CFG_SPACE_STEP, random_tuning_word());
			cfg_write(CFG_START_MARK, $urandom);
			case ($urandom_range(4))
				0: cfg_write(CFG_PWM_MODULUS, 32'd0);
				1: cfg_write(CFG_PWM_MODULUS, 32'd65535);
				2: cfg_write(CFG_PWM_MODULUS, 32'd1);
				default: cfg_write(CFG_PWM_MODULUS, $urandom);
			endcase
			cfg_write(CFG_INTERP_ENABLE, $urandom);
			if ($urandom_range(2) == 0) begin
				cfg_write(CFG_INDEX_W'(CFG_SPARE_LO + $urandom_range(2)), $urandom);
			end
			steady_flow = (ph == 4);
			for (int n = 0; n < 145; n++) begin
				send_tick($urandom_range(19) == 0, 1'b0, 16'sd0, 16'd0);
			end
		end
		steady_flow = 1'b0;

		drain();
		if (mismatches == 0) begin
			$display("nco_sine_pwm_duty_top_test: PASS");
		end else begin
			$display("nco_sine_pwm_duty_top_test: FAIL");
		end
		$finish;
	end

endmodule
